// ===== hdl/thnl_pkg.sv =====
// ----------------------------------------------------------------------------
// thnl_pkg
// Shared command codes and field widths for the timestamped history block.
// ----------------------------------------------------------------------------
package thnl_pkg;

  // field widths
  localparam int CMD_W   = 2;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LATEST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSEST = 2'd2;

endpackage

// ===== hdl/timestamped_history_nearest_lookup.sv =====
// ----------------------------------------------------------------------------
// timestamped_history_nearest_lookup
// Bounded ring history of (stamp, payload) records with newest-record and
// nearest-stamp lookups, held in two synchronous memories, each with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
//
//  channel   signals                               handshake
//  -------   -----------------------------------   --------------------------
//  command   command, stamp, payload               start high while busy low
//  result    found, stamp_out, payload_out         done, one cycle, no stall
//  config    capacity_wdata                        capacity_we, no wait
//
//  push, query on an empty history, unknown command: result the next cycle,
//    busy stays low
//  latest: one memory read into rd_stamp/rd_payload, then the result registers; busy in S_LATEST
//  closest: the scan reads one entry per cycle from the oldest record and
//    ends at the first stamp at or above the query or at the newest record
//  rst is synchronous; the memories are not cleared, only held entries are read
//  results cannot be held off; done marks each one for exactly one cycle
//
module timestamped_history_nearest_lookup #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          capacity_we,
  input  logic [thnl_pkg::CFG_W-1:0]    capacity_wdata,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [thnl_pkg::CMD_W-1:0]    command,
  input  logic [thnl_pkg::STAMP_W-1:0]  stamp,
  input  logic [PAYLOAD_WIDTH-1:0]      payload,
  // result
  output logic                          done,
  output logic                          found,
  output logic [thnl_pkg::STAMP_W-1:0]  stamp_out,
  output logic [PAYLOAD_WIDTH-1:0]      payload_out
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LATEST = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  // ring index wrap, sum stays below twice the depth
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] r;
    r = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
    return r[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  // record memories
  logic [thnl_pkg::STAMP_W-1:0] stamp_mem   [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]     payload_mem [DEPTH];

  logic [1:0]                   state;
  logic [SLOT_W-1:0]            oldest_slot;
  logic [CNT_W-1:0]             record_count;
  logic [CNT_W-1:0]             capacity;
  logic [thnl_pkg::STAMP_W-1:0] query_stamp;
  logic [SLOT_W-1:0]            scan_slot;
  logic [CNT_W-1:0]             scan_age;
  logic [thnl_pkg::STAMP_W-1:0] prev_stamp;
  logic [PAYLOAD_WIDTH-1:0]     prev_payload;
  logic [thnl_pkg::STAMP_W-1:0] prev_dist;
  logic [thnl_pkg::STAMP_W-1:0] rd_stamp;
  logic [PAYLOAD_WIDTH-1:0]     rd_payload;

  logic                         accept;
  logic                         has_room;
  logic [SLOT_W-1:0]            push_slot;
  logic [SLOT_W-1:0]            latest_slot;
  logic [SLOT_W-1:0]            scan_slot_next;
  logic [SLOT_W-1:0]            rd_addr;
  logic [thnl_pkg::STAMP_W-1:0] here_dist;
  logic                         here_hit;
  logic                         scan_last;
  logic [CNT_W-1:0]             cap_next;
  logic [31:0]                  cap_wide;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // slot arithmetic
  assign has_room       = (record_count < capacity);
  assign push_slot      = wrap_slot(SUM_W'(oldest_slot)
                                    + SUM_W'(has_room ? record_count : capacity));
  assign latest_slot    = wrap_slot(SUM_W'(oldest_slot) + SUM_W'(record_count - 1'b1));
  assign scan_slot_next = next_slot(scan_slot);

  // scan compare against the query stamp
  assign here_hit  = (rd_stamp >= query_stamp);
  assign here_dist = rd_stamp - query_stamp;
  assign scan_last = (scan_age == record_count - 1'b1);

  // capacity write value, zero becomes one, saturated to the depth
  assign cap_wide = {{(32 - thnl_pkg::CFG_W){1'b0}}, capacity_wdata};
  always_comb begin
    if (capacity_wdata == '0) begin
      cap_next = CNT_W'(1);
    end else if (cap_wide > 32'(DEPTH)) begin
      cap_next = CNT_W'(DEPTH);
    end else begin
      cap_next = cap_wide[CNT_W-1:0];
    end
  end

  // read address select
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = scan_slot_next;
    end else if (command == thnl_pkg::CMD_LATEST) begin
      rd_addr = latest_slot;
    end else begin
      rd_addr = oldest_slot;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (accept && command == thnl_pkg::CMD_PUSH) begin
      stamp_mem[push_slot]   <= stamp;
      payload_mem[push_slot] <= payload;
    end
    rd_stamp   <= stamp_mem[rd_addr];
    rd_payload <= payload_mem[rd_addr];
  end

  // control and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      oldest_slot  <= '0;
      record_count <= '0;
      capacity     <= CNT_W'(DEPTH);
      done         <= 1'b0;
      found        <= 1'b0;
      stamp_out    <= '0;
      payload_out  <= '0;
    end else begin
      done <= 1'b0;
      if (capacity_we && record_count == '0) begin
        capacity <= cap_next;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            query_stamp <= stamp;
            scan_slot   <= oldest_slot;
            scan_age    <= '0;
            case (command) inside
              thnl_pkg::CMD_PUSH: begin
                if (has_room) begin
                  record_count <= record_count + 1'b1;
                end else begin
                  oldest_slot <= next_slot(oldest_slot);
                end
                done        <= 1'b1;
                found       <= 1'b1;
                stamp_out   <= stamp;
                payload_out <= payload;
              end
              thnl_pkg::CMD_LATEST, thnl_pkg::CMD_CLOSEST: begin
                if (record_count == '0) begin
                  done        <= 1'b1;
                  found       <= 1'b0;
                  stamp_out   <= '0;
                  payload_out <= '0;
                end else begin
                  state <= (command == thnl_pkg::CMD_LATEST) ? S_LATEST : S_SCAN;
                end
              end
              default: begin
                done        <= 1'b1;
                found       <= 1'b0;
                stamp_out   <= '0;
                payload_out <= '0;
              end
            endcase
          end
        end
        S_LATEST: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          found       <= 1'b1;
          stamp_out   <= rd_stamp;
          payload_out <= rd_payload;
        end
        S_SCAN: begin
          if (here_hit) begin
            // first qualifying record, pick the nearer of it and its predecessor
            state <= S_IDLE;
            done  <= 1'b1;
            found <= 1'b1;
            if (scan_age != '0 && !(here_dist < prev_dist)) begin
              stamp_out   <= prev_stamp;
              payload_out <= prev_payload;
            end else begin
              stamp_out   <= rd_stamp;
              payload_out <= rd_payload;
            end
          end else if (scan_last) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            found       <= 1'b0;
            stamp_out   <= '0;
            payload_out <= '0;
          end else begin
            prev_stamp   <= rd_stamp;
            prev_payload <= rd_payload;
            prev_dist    <= query_stamp - rd_stamp;
            scan_slot    <= scan_slot_next;
            scan_age     <= scan_age + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/thnl_checker.sv =====
// ----------------------------------------------------------------------------
// thnl_checker
// Port-level checks on the timestamped history block, bound to the top level.
// ----------------------------------------------------------------------------
module thnl_checker #(
  parameter int PAYLOAD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [thnl_pkg::CMD_W-1:0]    command,
  input logic [thnl_pkg::STAMP_W-1:0]  stamp,
  input logic                          done,
  input logic                          found,
  input logic [thnl_pkg::STAMP_W-1:0]  stamp_out,
  input logic [PAYLOAD_WIDTH-1:0]      payload_out
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  // a result always ends the work, never shows while still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  // a failed lookup carries zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
      done && !found |-> stamp_out == '0 && payload_out == '0)
    else $error("failed lookup with nonzero fields");

  // a push answers the next cycle and echoes its stamp
  a_push_echo: assert property (@(posedge clk) disable iff (rst)
      start && !busy && command == thnl_pkg::CMD_PUSH
      |=> done && found && stamp_out == $past(stamp))
    else $error("push result missing or wrong");

  // a command code with no meaning fails at once
  a_bad_cmd: assert property (@(posedge clk) disable iff (rst)
      start && !busy && command != thnl_pkg::CMD_PUSH
      && command != thnl_pkg::CMD_LATEST && command != thnl_pkg::CMD_CLOSEST
      |=> done && !found)
    else $error("unknown command not rejected");

endmodule

bind timestamped_history_nearest_lookup thnl_checker #(
  .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
) u_thnl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .command    (command),
  .stamp      (stamp),
  .done       (done),
  .found      (found),
  .stamp_out  (stamp_out),
  .payload_out(payload_out)
);
